FILE: hdl/ctv_pkg.sv
// ----------------------------------------------------------------------------
// ctv_pkg
// Shared widths, register codes, control types and helpers for the cursor
// transform and velocity block.
// ----------------------------------------------------------------------------
package ctv_pkg;

	// sample width of the tracker front end, sign extended from at most 16 bits
	localparam int SAMPLE_WIDTH = 16;
	localparam int SampleEff = (SAMPLE_WIDTH < 16) ? SAMPLE_WIDTH : 16;

	// field widths
	localparam int PosW = 16;
	localparam int SpeedW = 15;
	localparam int CfgW = 32;
	localparam int CfgIdxW = 3;

	// datapath widths
	localparam int NumW = PosW + 3;
	localparam int AbsW = NumW - 1;
	localparam int DiffW = PosW + 1;
	localparam int MacW = NumW;
	localparam int AccW = 2 * MacW + 2;
	localparam int RootW = 18;
	localparam int RadW = 2 * RootW;
	localparam int ExtW = PosW + 8;

	// divide by ten as multiply by reciprocal, exact below 2^18
	localparam int DivTenMul = 209716;
	localparam int DivTenShift = 21;

	// fixed point rounding
	localparam int RoundMat = 2048;
	localparam int ShMat = 12;
	localparam int RoundClamp = 8192;
	localparam int ShClamp = 14;

	// mode bits
	localparam int ModeMirrorBit = 0;
	localparam int ModeClampBit = 1;

	// register indexes
	typedef enum logic [CfgIdxW-1:0] {
		REG_MAT_XX     = 3'd0,
		REG_MAT_XY     = 3'd1,
		REG_MAT_YX     = 3'd2,
		REG_MAT_YY     = 3'd3,
		REG_ORIGIN     = 3'd4,
		REG_OFFSET     = 3'd5,
		REG_CLAMP_DIR  = 3'd6,
		REG_MODE       = 3'd7
	} ctv_reg_t;

	// shared multiplier command
	typedef struct packed {
		logic en;
		logic accum;
	} ctv_mac_ctl_t;

	// square root unit status
	typedef struct packed {
		logic busy;
		logic done;
	} ctv_sqrt_stat_t;

	// sign extend a sample from its effective width
	function automatic logic signed [PosW-1:0] sext_sample(input logic [PosW-1:0] v);
		logic signed [PosW-1:0] t;
		t = $signed(v << (PosW - SampleEff));
		return t >>> (PosW - SampleEff);
	endfunction

	// saturate to a 16 bit signed position
	function automatic logic signed [PosW-1:0] sat_pos(input logic signed [ExtW-1:0] v);
		logic signed [ExtW-1:0] hi;
		logic signed [ExtW-1:0] lo;
		hi = ExtW'(32767);
		lo = -ExtW'(32768);
		if (v > hi) begin
			return 16'sh7fff;
		end else if (v < lo) begin
			return 16'sh8000;
		end
		return v[PosW-1:0];
	endfunction

endpackage

FILE: hdl/ctv_in_if.sv
// ----------------------------------------------------------------------------
// ctv_in_if
// Sample channel: one hand position item per handshake.
// ----------------------------------------------------------------------------
interface ctv_in_if;
	logic valid;
	logic ready;
	logic signed [ctv_pkg::PosW-1:0] sample_x;
	logic signed [ctv_pkg::PosW-1:0] sample_y;

	modport source(output valid, sample_x, sample_y, input ready);
	modport sink(input valid, sample_x, sample_y, output ready);
endinterface

FILE: hdl/ctv_out_if.sv
// ----------------------------------------------------------------------------
// ctv_out_if
// Result channel: cursor position, velocity and speed per item.
// ----------------------------------------------------------------------------
interface ctv_out_if;
	logic valid;
	logic ready;
	logic signed [ctv_pkg::PosW-1:0] screen_x;
	logic signed [ctv_pkg::PosW-1:0] screen_y;
	logic signed [ctv_pkg::PosW-1:0] velocity_x;
	logic signed [ctv_pkg::PosW-1:0] velocity_y;
	logic [ctv_pkg::SpeedW-1:0] speed;

	modport source(output valid, screen_x, screen_y, velocity_x, velocity_y, speed,
		input ready);
	modport sink(input valid, screen_x, screen_y, velocity_x, velocity_y, speed,
		output ready);
endinterface

FILE: hdl/cursor_transform_velocity.sv
// ----------------------------------------------------------------------------
// cursor_transform_velocity
// Hand position to cursor transform with five-point velocity and speed.
// ----------------------------------------------------------------------------
// One sample item is taken at a time; the next sample can be taken in the
// cycle after the result is registered. The throughput is set by the single
// shared multiply-accumulate unit, which runs the divide-by-ten, the squares
// and the matrix or clamp products one after another, and by two passes
// (radius, then speed) through the shared square root unit at two root bits
// per cycle. A finished result waits in the output register while the next
// sample is accepted. The user must write configuration registers through
// the plain write port only while the block is idle; the block itself does
// not enforce this.
// ----------------------------------------------------------------------------
module cursor_transform_velocity (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [ctv_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [ctv_pkg::CfgW-1:0] cfg_data,
	ctv_in_if.sink sample_ch,
	ctv_out_if.source result_ch
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIVX,
		S_DIVY,
		S_VX,
		S_VY,
		S_SQX,
		S_SQY,
		S_ROOTR,
		S_X1,
		S_X2,
		S_Y1,
		S_Y2,
		S_YW,
		S_YCAP,
		S_SWAIT
	} state_t;

	localparam int PosW = ctv_pkg::PosW;
	localparam int MacW = ctv_pkg::MacW;
	localparam int AccW = ctv_pkg::AccW;
	localparam int ExtW = ctv_pkg::ExtW;
	localparam int RW = ctv_pkg::RootW - 1;

	state_t state_q;

	// configuration registers
	logic signed [PosW-1:0] mat_xx_q, mat_xy_q, mat_yx_q, mat_yy_q;
	logic [ctv_pkg::CfgW-1:0] origin_q, offset_q, clamp_dir_q;
	logic [1:0] mode_q;

	// sample history, newest first
	logic signed [PosW-1:0] past_x_q [4];
	logic signed [PosW-1:0] past_y_q [4];

	// per item working registers
	logic [ctv_pkg::AbsW-1:0] abs_x_q, abs_y_q;
	logic neg_x_q, neg_y_q;
	logic signed [ctv_pkg::DiffW-1:0] dx_q, dy_q;
	logic signed [PosW-1:0] vx_q, vy_q;
	logic [RW-1:0] r_q;
	logic signed [PosW-1:0] scx_q, scy_q;

	// output register
	logic out_valid_q;
	logic signed [PosW-1:0] out_sx_q, out_sy_q, out_vx_q, out_vy_q;
	logic [ctv_pkg::SpeedW-1:0] out_spd_q;

	// shared units
	ctv_pkg::ctv_mac_ctl_t mac_ctl;
	logic signed [MacW-1:0] op_a, op_b;
	logic signed [AccW-1:0] acc_w;
	logic sq_start;
	ctv_pkg::ctv_sqrt_stat_t sq_stat;
	logic [ctv_pkg::RootW-1:0] sq_root;

	// combinational helpers
	logic take;
	logic clamp, mirror;
	logic signed [PosW-1:0] sx, sy, ox, oy, fx, fy;
	logic signed [ctv_pkg::NumW-1:0] num_x, num_y;
	logic [PosW-1:0] q_div;
	logic signed [PosW-1:0] vel_w;
	logic is_x;
	logic signed [AccW-1:0] rsum;
	logic signed [ExtW-1:0] base, org, off, pos;
	logic signed [PosW-1:0] fin;
	logic out_free;
	logic load_out;

	assign take = sample_ch.valid && sample_ch.ready;
	assign sample_ch.ready = (state_q == S_IDLE);
	assign clamp = mode_q[ctv_pkg::ModeClampBit];
	assign mirror = mode_q[ctv_pkg::ModeMirrorBit];
	assign ox = $signed(origin_q[31:16]);
	assign oy = $signed(origin_q[15:0]);
	assign fx = $signed(offset_q[31:16]);
	assign fy = $signed(offset_q[15:0]);
	assign out_free = !out_valid_q || result_ch.ready;
	assign load_out = (state_q == S_SWAIT) && !sq_stat.busy && out_free;

	// five-point slope numerators from the incoming sample
	always_comb begin
		sx = ctv_pkg::sext_sample(sample_ch.sample_x);
		sy = ctv_pkg::sext_sample(sample_ch.sample_y);
		num_x = (ctv_pkg::NumW'(sx) <<< 1) + ctv_pkg::NumW'(past_x_q[0])
			- ctv_pkg::NumW'(past_x_q[2]) - (ctv_pkg::NumW'(past_x_q[3]) <<< 1);
		num_y = (ctv_pkg::NumW'(sy) <<< 1) + ctv_pkg::NumW'(past_y_q[0])
			- ctv_pkg::NumW'(past_y_q[2]) - (ctv_pkg::NumW'(past_y_q[3]) <<< 1);
	end

	// quotient by ten, sign restored (truncation toward zero)
	always_comb begin
		q_div = acc_w[ctv_pkg::DivTenShift +: PosW];
		if ((state_q == S_VX) ? neg_x_q : neg_y_q) begin
			vel_w = -$signed(q_div);
		end else begin
			vel_w = $signed(q_div);
		end
	end

	// round, shift, add origin (and offset, with mirror, in matrix mode), saturate
	always_comb begin
		is_x = (state_q == S_Y2);
		org = ExtW'(is_x ? ox : oy);
		off = ExtW'(is_x ? fx : fy);
		if (clamp) begin
			rsum = acc_w + AccW'(ctv_pkg::RoundClamp);
			base = ExtW'(rsum >>> ctv_pkg::ShClamp);
			pos = base + org;
		end else begin
			rsum = acc_w + AccW'(ctv_pkg::RoundMat);
			base = ExtW'(rsum >>> ctv_pkg::ShMat);
			pos = base + org + off;
			if (is_x && mirror) begin
				pos = (org <<< 1) - pos;
			end
		end
		fin = ctv_pkg::sat_pos(pos);
	end

	// multiplier schedule
	always_comb begin
		mac_ctl = '0;
		op_a = '0;
		op_b = '0;
		unique case (state_q)
			S_DIVX: begin
				mac_ctl = '{en: 1'b1, accum: 1'b0};
				op_a = $signed({1'b0, abs_x_q});
				op_b = MacW'(ctv_pkg::DivTenMul);
			end
			S_DIVY: begin
				mac_ctl = '{en: 1'b1, accum: 1'b0};
				op_a = $signed({1'b0, abs_y_q});
				op_b = MacW'(ctv_pkg::DivTenMul);
			end
			S_VX: begin
				mac_ctl = '{en: 1'b1, accum: 1'b0};
				op_a = MacW'(dx_q);
				op_b = MacW'(dx_q);
			end
			S_VY: begin
				mac_ctl = '{en: 1'b1, accum: 1'b1};
				op_a = MacW'(dy_q);
				op_b = MacW'(dy_q);
			end
			S_SQX: begin
				mac_ctl = '{en: 1'b1, accum: 1'b0};
				op_a = MacW'(vx_q);
				op_b = MacW'(vx_q);
			end
			S_SQY: begin
				mac_ctl = '{en: 1'b1, accum: 1'b1};
				op_a = MacW'(vy_q);
				op_b = MacW'(vy_q);
			end
			S_X1: begin
				mac_ctl = '{en: 1'b1, accum: 1'b0};
				op_a = clamp ? MacW'($signed({1'b0, r_q})) : MacW'(mat_xx_q);
				op_b = clamp ? MacW'($signed(clamp_dir_q[31:16])) : MacW'(dx_q);
			end
			S_X2: begin
				mac_ctl = '{en: 1'b1, accum: 1'b1};
				op_a = clamp ? '0 : MacW'(mat_xy_q);
				op_b = MacW'(dy_q);
			end
			S_Y1: begin
				mac_ctl = '{en: 1'b1, accum: 1'b0};
				op_a = clamp ? MacW'($signed({1'b0, r_q})) : MacW'(mat_yx_q);
				op_b = clamp ? MacW'($signed(clamp_dir_q[15:0])) : MacW'(dx_q);
			end
			S_Y2: begin
				mac_ctl = '{en: 1'b1, accum: 1'b1};
				op_a = clamp ? '0 : MacW'(mat_yy_q);
				op_b = MacW'(dy_q);
			end
			default: begin
				mac_ctl = '0;
			end
		endcase
	end

	// radius root starts on dx^2 + dy^2, speed root on vx^2 + vy^2
	assign sq_start = (state_q == S_SQY) || ((state_q == S_ROOTR) && !sq_stat.busy);

	ctv_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.op_a   (op_a),
		.op_b   (op_b),
		.acc    (acc_w)
	);

	ctv_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (acc_w[ctv_pkg::RadW-1:0]),
		.stat     (sq_stat),
		.root     (sq_root)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_xx_q <= 16'sd4096;
			mat_xy_q <= '0;
			mat_yx_q <= '0;
			mat_yy_q <= 16'sd4096;
			origin_q <= 32'h2000_2000;
			offset_q <= '0;
			clamp_dir_q <= '0;
			mode_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ctv_pkg::REG_MAT_XX:    mat_xx_q <= $signed(cfg_data[PosW-1:0]);
				ctv_pkg::REG_MAT_XY:    mat_xy_q <= $signed(cfg_data[PosW-1:0]);
				ctv_pkg::REG_MAT_YX:    mat_yx_q <= $signed(cfg_data[PosW-1:0]);
				ctv_pkg::REG_MAT_YY:    mat_yy_q <= $signed(cfg_data[PosW-1:0]);
				ctv_pkg::REG_ORIGIN:    origin_q <= cfg_data;
				ctv_pkg::REG_OFFSET:    offset_q <= cfg_data;
				ctv_pkg::REG_CLAMP_DIR: clamp_dir_q <= cfg_data;
				ctv_pkg::REG_MODE:      mode_q <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	// sample history shifts on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				past_x_q[i] <= '0;
				past_y_q[i] <= '0;
			end
		end else if (take) begin
			for (int i = 3; i > 0; i--) begin
				past_x_q[i] <= past_x_q[i-1];
				past_y_q[i] <= past_y_q[i-1];
			end
			past_x_q[0] <= sx;
			past_y_q[0] <= sy;
		end
	end

	// per item working registers
	always_ff @(posedge clk) begin
		if (take) begin
			neg_x_q <= num_x[ctv_pkg::NumW-1];
			neg_y_q <= num_y[ctv_pkg::NumW-1];
			abs_x_q <= num_x[ctv_pkg::NumW-1] ? ctv_pkg::AbsW'(-num_x)
				: ctv_pkg::AbsW'(num_x);
			abs_y_q <= num_y[ctv_pkg::NumW-1] ? ctv_pkg::AbsW'(-num_y)
				: ctv_pkg::AbsW'(num_y);
			dx_q <= ctv_pkg::DiffW'(sx) - ctv_pkg::DiffW'(ox);
			dy_q <= ctv_pkg::DiffW'(sy) - ctv_pkg::DiffW'(oy);
		end
		if (state_q == S_VX) begin
			vx_q <= vel_w;
		end
		if (state_q == S_VY) begin
			vy_q <= vel_w;
		end
		if ((state_q == S_ROOTR) && !sq_stat.busy) begin
			r_q <= sq_root[RW-1:0];
		end
		if (state_q == S_Y2) begin
			scx_q <= fin;
		end
		if (state_q == S_YCAP) begin
			scy_q <= fin;
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			out_sx_q <= '0;
			out_sy_q <= '0;
			out_vx_q <= '0;
			out_vy_q <= '0;
			out_spd_q <= '0;
		end else begin
			// result register fills from the last step, empties on a handshake
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE:  if (take) state_q <= S_DIVX;
				S_DIVX:  state_q <= S_DIVY;
				S_DIVY:  state_q <= S_VX;
				S_VX:    state_q <= S_VY;
				S_VY:    state_q <= S_SQX;
				S_SQX:   state_q <= S_SQY;
				S_SQY:   state_q <= S_ROOTR;
				S_ROOTR: if (!sq_stat.busy) state_q <= S_X1;
				S_X1:    state_q <= S_X2;
				S_X2:    state_q <= S_Y1;
				S_Y1:    state_q <= S_Y2;
				S_Y2:    state_q <= S_YW;
				S_YW:    state_q <= S_YCAP;
				S_YCAP:  state_q <= S_SWAIT;
				S_SWAIT: begin
					if (load_out) begin
						out_sx_q <= scx_q;
						out_sy_q <= scy_q;
						out_vx_q <= vx_q;
						out_vy_q <= vy_q;
						out_spd_q <= sq_root[ctv_pkg::SpeedW-1:0];
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result_ch.valid = out_valid_q;
	assign result_ch.screen_x = out_sx_q;
	assign result_ch.screen_y = out_sy_q;
	assign result_ch.velocity_x = out_vx_q;
	assign result_ch.velocity_y = out_vy_q;
	assign result_ch.speed = out_spd_q;

	// checks
	a_take_starts: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (state_q == S_DIVX)) else $error("accepted item did not start the sequence");
	a_result_from_wait: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_SWAIT))
		else $error("result loaded outside the final step");
	a_vel_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_vx_q <= 16'sd19660 && out_vx_q >= -16'sd19660
			&& out_vy_q <= 16'sd19660 && out_vy_q >= -16'sd19660))
		else $error("velocity outside the five-point slope range");

endmodule

FILE: hdl/ctv_mac.sv
// ----------------------------------------------------------------------------
// ctv_mac
// Shared signed multiply-accumulate unit: registered product, then the
// accumulator either loads or adds it in the following cycle.
// ----------------------------------------------------------------------------
module ctv_mac (
	input  logic clk,
	input  logic arst_n,
	input  ctv_pkg::ctv_mac_ctl_t ctl,
	input  logic signed [ctv_pkg::MacW-1:0] op_a,
	input  logic signed [ctv_pkg::MacW-1:0] op_b,
	output logic signed [ctv_pkg::AccW-1:0] acc
);

	ctv_pkg::ctv_mac_ctl_t ctl_s1;
	logic signed [2*ctv_pkg::MacW-1:0] prod_s1;
	logic signed [ctv_pkg::AccW-1:0] acc_q;

	// command follows the product register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

	// product, then load or accumulate
	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
		if (ctl_s1.en) begin
			acc_q <= (ctl_s1.accum ? acc_q : '0) + ctv_pkg::AccW'(prod_s1);
		end
	end

	assign acc = acc_q;

endmodule

FILE: hdl/ctv_isqrt.sv
// ----------------------------------------------------------------------------
// ctv_isqrt
// Floor integer square root, restoring digit method, two root bits per cycle.
// ----------------------------------------------------------------------------
module ctv_isqrt (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [ctv_pkg::RadW-1:0] radicand,
	output ctv_pkg::ctv_sqrt_stat_t stat,
	output logic [ctv_pkg::RootW-1:0] root
);

	localparam int StepsPerCycle = 2;
	localparam int Cycles = ctv_pkg::RootW / StepsPerCycle;
	localparam int CntW = $clog2(Cycles);
	localparam int RemW = ctv_pkg::RootW + 3;
	localparam logic [CntW-1:0] LastCnt = CntW'(Cycles - 1);

	logic busy_q;
	logic [CntW-1:0] cnt_q;
	logic [ctv_pkg::RadW-1:0] rad_q;
	logic [RemW-1:0] rem_q;
	logic [ctv_pkg::RootW-1:0] root_q;

	logic [ctv_pkg::RadW-1:0] rad_v;
	logic [RemW-1:0] rem_v;
	logic [RemW-1:0] trial;
	logic [ctv_pkg::RootW-1:0] root_v;
	logic done;

	// two restoring steps per cycle
	always_comb begin
		rad_v = rad_q;
		rem_v = rem_q;
		root_v = root_q;
		trial = '0;
		for (int i = 0; i < StepsPerCycle; i++) begin
			rem_v = {rem_v[RemW-3:0], rad_v[ctv_pkg::RadW-1 -: 2]};
			rad_v = {rad_v[ctv_pkg::RadW-3:0], 2'b00};
			trial = {1'b0, root_v, 2'b01};
			if (rem_v >= trial) begin
				rem_v = rem_v - trial;
				root_v = {root_v[ctv_pkg::RootW-2:0], 1'b1};
			end else begin
				root_v = {root_v[ctv_pkg::RootW-2:0], 1'b0};
			end
		end
	end

	assign done = busy_q && (cnt_q == LastCnt);

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= radicand;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= rad_v;
			rem_q <= rem_v;
			root_q <= root_v;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done;
	assign root = root_q;

	// checks
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q) else $error("square root did not start");
	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !start) |=> !busy_q) else $error("square root ran past its last step");
	a_busy_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !done) |=> busy_q) else $error("square root stopped early");

endmodule
